// File: design/hpsf_pkg.sv
package hpsf_pkg;

    // Command carried with each input beat.
    typedef enum logic [1:0] {
        FUNC_POLL     = 2'd0,
        FUNC_SHUTDOWN = 2'd1,
        FUNC_CYCLE    = 2'd2,
        FUNC_NOTIFY   = 2'd3
    } t_func;

    // Reported status codes.
    localparam logic [2:0] ST_UNKNOWN   = 3'd0;
    localparam logic [2:0] ST_OFF       = 3'd1;
    localparam logic [2:0] ST_BOOTING   = 3'd2;
    localparam logic [2:0] ST_BOOT_SLOW = 3'd3;
    localparam logic [2:0] ST_RUNNING   = 3'd4;
    localparam logic [2:0] ST_HALTING   = 3'd5;
    localparam logic [2:0] ST_HALT_SLOW = 3'd6;
    localparam logic [2:0] ST_HALTED    = 3'd7;

    // Power command codes.
    localparam logic [1:0] PCMD_NONE    = 2'd0;
    localparam logic [1:0] PCMD_ENABLE  = 2'd1;
    localparam logic [1:0] PCMD_DISABLE = 2'd2;

    // Configuration port.
    localparam int          APB_AW          = 3;
    localparam int          APB_DW          = 32;
    localparam int          TIMEOUT_W       = 24;
    localparam logic        REG_FAILSAFE    = 1'b0;
    localparam logic [23:0] TIMEOUT_RESET   = 24'd60000;

    // Stream widths.
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        t_func       func;
        logic [31:0] now_ms;
        logic        host_alive;
        logic        power_present;
        logic        auto_power;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic       shutdown_line;
        logic [1:0] power_command;
        logic       power_off_event;
        logic       notify_armed;
        logic       stable;
    } t_result;

endpackage

// File: design/hpsf_cfg.sv
module hpsf_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hpsf_pkg::APB_AW-1:0]           paddr,
    input  logic [hpsf_pkg::APB_DW-1:0]           pwdata,
    output logic [hpsf_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready,
    output logic [hpsf_pkg::TIMEOUT_W-1:0]        o_timeout
);

    logic [hpsf_pkg::TIMEOUT_W-1:0] r_timeout;
    logic                           w_sel_failsafe;

    assign w_sel_failsafe = (paddr[2] == hpsf_pkg::REG_FAILSAFE);
    assign pready         = 1'b1;

    // Register write on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= hpsf_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && w_sel_failsafe) begin
            r_timeout <= pwdata[hpsf_pkg::TIMEOUT_W-1:0];
        end
    end

    // Read mux; addresses beyond the register read as zero.
    always_comb begin
        if (w_sel_failsafe) begin
            prdata = {{(hpsf_pkg::APB_DW - hpsf_pkg::TIMEOUT_W){1'b0}}, r_timeout};
        end else begin
            prdata = '0;
        end
    end

    assign o_timeout = r_timeout;

endmodule

// File: design/hpsf_core.sv
module hpsf_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  hpsf_pkg::t_item                 i_item,
    input  logic [hpsf_pkg::TIMEOUT_W-1:0]  i_timeout,
    output hpsf_pkg::t_result               o_result
);

    typedef enum logic [7:0] {
        S_UNKNOWN   = 8'b0000_0001,
        S_OFF       = 8'b0000_0010,
        S_BOOTING   = 8'b0000_0100,
        S_BOOT_SLOW = 8'b0000_1000,
        S_RUNNING   = 8'b0001_0000,
        S_HALTING   = 8'b0010_0000,
        S_HALT_SLOW = 8'b0100_0000,
        S_HALTED    = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_last, n_last;
    logic        r_cycle, n_cycle;
    logic        r_notify, n_notify;
    logic        r_shut, n_shut;

    t_state      w_target;
    logic        w_set;
    logic        w_force_unknown;
    logic        w_timed_out;
    logic [31:0] w_elapsed;
    logic [1:0]  w_pcmd;
    logic        w_event;
    logic [2:0]  w_status;

    // Time since the last status change, wrapping, compared unsigned.
    assign w_elapsed   = i_item.now_ms - r_last;
    assign w_timed_out = w_elapsed > {8'd0, i_timeout};

    // Next-state logic for one beat.
    always_comb begin
        n_state         = r_state;
        n_last          = r_last;
        n_cycle         = r_cycle;
        n_notify        = r_notify;
        n_shut          = r_shut;
        w_target        = r_state;
        w_set           = 1'b0;
        w_force_unknown = 1'b0;
        w_pcmd          = hpsf_pkg::PCMD_NONE;
        w_event         = 1'b0;

        if (i_item.func == hpsf_pkg::FUNC_SHUTDOWN || i_item.func == hpsf_pkg::FUNC_CYCLE) begin
            if (i_item.func == hpsf_pkg::FUNC_CYCLE) begin
                n_cycle = 1'b1;
            end
            if (r_state == S_RUNNING || r_state == S_BOOTING) begin
                w_set    = 1'b1;
                w_target = S_HALTING;
                n_shut   = 1'b1;
            end
        end else if (i_item.func == hpsf_pkg::FUNC_NOTIFY) begin
            n_notify = 1'b1;
        end else if (r_state != S_OFF && !i_item.power_present) begin
            // Power lost: go off, and back to unknown when notification is armed.
            w_set    = 1'b1;
            w_target = S_OFF;
            n_shut   = 1'b0;
            if (r_notify) begin
                w_event         = 1'b1;
                n_notify        = 1'b0;
                w_force_unknown = 1'b1;
            end
        end else begin
            case (r_state)
                S_UNKNOWN: begin
                    // Leaving unknown does not record the time.
                    n_shut = 1'b0;
                    if (i_item.host_alive) begin
                        n_state = S_RUNNING;
                    end else if (i_item.power_present) begin
                        n_state = S_BOOTING;
                    end else begin
                        n_state = S_OFF;
                    end
                end
                S_OFF: begin
                    if (i_item.power_present && !i_item.host_alive) begin
                        w_set    = 1'b1;
                        w_target = S_BOOTING;
                    end else if (i_item.host_alive) begin
                        // Alive without power means the power switch is bypassed.
                        w_set    = 1'b1;
                        w_target = S_RUNNING;
                    end else if (r_cycle) begin
                        w_pcmd   = hpsf_pkg::PCMD_ENABLE;
                        n_cycle  = 1'b0;
                        w_set    = 1'b1;
                        w_target = S_BOOTING;
                    end
                end
                S_RUNNING: begin
                    if (!i_item.host_alive) begin
                        w_set    = 1'b1;
                        w_target = S_HALTED;
                    end
                end
                S_BOOTING: begin
                    if (i_item.host_alive) begin
                        w_set    = 1'b1;
                        w_target = S_RUNNING;
                    end else if (w_timed_out) begin
                        w_set    = 1'b1;
                        w_target = S_BOOT_SLOW;
                    end
                end
                S_BOOT_SLOW: begin
                    if (i_item.host_alive) begin
                        w_set    = 1'b1;
                        w_target = S_RUNNING;
                    end
                end
                S_HALTING: begin
                    if (!i_item.host_alive) begin
                        w_set    = 1'b1;
                        w_target = S_HALTED;
                    end else if (w_timed_out) begin
                        w_set    = 1'b1;
                        w_target = S_HALT_SLOW;
                    end
                end
                S_HALT_SLOW: begin
                    if (!i_item.host_alive) begin
                        w_set    = 1'b1;
                        w_target = S_HALTED;
                    end
                    if (i_item.auto_power) begin
                        w_pcmd = hpsf_pkg::PCMD_DISABLE;
                    end
                end
                default: begin
                    // Halted.
                    n_shut = 1'b0;
                    if (i_item.host_alive) begin
                        w_set    = 1'b1;
                        w_target = S_RUNNING;
                    end
                    if (i_item.auto_power) begin
                        w_pcmd = hpsf_pkg::PCMD_DISABLE;
                    end
                end
            endcase
        end

        // A status change through the normal path records the time.
        if (w_set && w_target != r_state) begin
            n_state = w_target;
            n_last  = i_item.now_ms;
        end
        if (w_force_unknown) begin
            n_state = S_UNKNOWN;
        end
    end

    // State registers advance once per processed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_UNKNOWN;
            r_last   <= '0;
            r_cycle  <= 1'b0;
            r_notify <= 1'b0;
            r_shut   <= 1'b0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_cycle  <= n_cycle;
            r_notify <= n_notify;
            r_shut   <= n_shut;
        end
    end

    // Encode the one-hot state into the reported status.
    always_comb begin
        case (n_state)
            S_UNKNOWN:   w_status = hpsf_pkg::ST_UNKNOWN;
            S_OFF:       w_status = hpsf_pkg::ST_OFF;
            S_BOOTING:   w_status = hpsf_pkg::ST_BOOTING;
            S_BOOT_SLOW: w_status = hpsf_pkg::ST_BOOT_SLOW;
            S_RUNNING:   w_status = hpsf_pkg::ST_RUNNING;
            S_HALTING:   w_status = hpsf_pkg::ST_HALTING;
            S_HALT_SLOW: w_status = hpsf_pkg::ST_HALT_SLOW;
            S_HALTED:    w_status = hpsf_pkg::ST_HALTED;
            default:     w_status = hpsf_pkg::ST_UNKNOWN;
        endcase
    end

    // Result reflects the state after this beat.
    always_comb begin
        o_result.status          = w_status;
        o_result.shutdown_line   = n_shut;
        o_result.power_command   = w_pcmd;
        o_result.power_off_event = w_event;
        o_result.notify_armed    = n_notify;
        o_result.stable          = !(n_cycle && n_state == S_OFF)
                                   && (n_state == S_RUNNING || n_state == S_OFF);
    end

endmodule

// File: design/host_power_sequencer_fsm.sv
// Host power sequencer.
//
// Input beats arrive on the s_axis channel: tuser carries the command (poll,
// shutdown request, power-cycle request, arm power-off notify) and tdata the
// millisecond time and the host-alive, power-present and auto-power flags.
// Every input beat produces exactly one result beat on m_axis carrying the
// status, the shutdown line level, a power command, the power-off event, the
// notify flag and the stable flag.
//
// A taken beat is held in the input register, decoded against the state by
// the next-state logic, and its result is registered in the result register,
// from which it is offered. One beat is taken per cycle while the result is
// not stalled; the single next-state stage between the input and result
// registers sets that rate. When the receiver stalls, the result register holds
// and the input register absorbs one more beat before s_axis_tready drops.
//
// Reset clears the status to unknown, the stored time and all flags, and sets
// the failsafe timeout to 60000 ms. The user must write it over the APB port
// at byte address 0 while no beat is in flight; the block does not enforce it.
module host_power_sequencer_fsm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: now_ms[31:0], host_alive[32], power_present[33], auto_power[34].
    input  logic [hpsf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: func[1:0].
    input  logic [hpsf_pkg::IN_USER_W-1:0]       s_axis_tuser,
    // Result channel.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: status[2:0], shutdown_line[3], power_command[5:4],
    // power_off_event[6], notify_armed[7], stable[8].
    output logic [hpsf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hpsf_pkg::APB_AW-1:0]          paddr,
    input  logic [hpsf_pkg::APB_DW-1:0]          pwdata,
    output logic [hpsf_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);

    logic                           r_in_valid;
    hpsf_pkg::t_item                r_item;
    logic                           r_out_valid;
    hpsf_pkg::t_result              r_res;
    hpsf_pkg::t_result              w_res;
    logic                           w_advance;
    logic                           w_take;
    logic [hpsf_pkg::TIMEOUT_W-1:0] w_timeout;

    // Handshake: the input stage moves on whenever the result register frees.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.func          <= hpsf_pkg::t_func'(s_axis_tuser[1:0]);
            r_item.now_ms        <= s_axis_tdata[31:0];
            r_item.host_alive    <= s_axis_tdata[32];
            r_item.power_present <= s_axis_tdata[33];
            r_item.auto_power    <= s_axis_tdata[34];
        end
    end

    hpsf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (w_timeout)
    );

    hpsf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_item    (r_item),
        .i_timeout (w_timeout),
        .o_result  (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_res.stable, r_res.notify_armed, r_res.power_off_event,
                            r_res.power_command, r_res.shutdown_line, r_res.status};

endmodule

// File: design/hpsf_checker.sv
module hpsf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [hpsf_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    // A power-off event consumes the notification.
    a_event_clears_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |-> !m_axis_tdata[7])
        else $error("power-off event with notification still armed");

    // A power-off event leaves the status unknown and the shutdown line low.
    a_event_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6])
            |-> (m_axis_tdata[2:0] == hpsf_pkg::ST_UNKNOWN && !m_axis_tdata[3]))
        else $error("power-off event with wrong status or shutdown line");

    // Stable is only reported when running or off.
    a_stable_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8])
            |-> (m_axis_tdata[2:0] == hpsf_pkg::ST_RUNNING
                 || m_axis_tdata[2:0] == hpsf_pkg::ST_OFF))
        else $error("stable reported outside running or off");

    // Power is only enabled to start a boot.
    a_enable_boots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5:4] == hpsf_pkg::PCMD_ENABLE)
            |-> (m_axis_tdata[2:0] == hpsf_pkg::ST_BOOTING))
        else $error("power enable without entering booting");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat dropped or changed");

endmodule

bind host_power_sequencer_fsm hpsf_checker u_hpsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
